// ===== rtl/core/vws_pkg.sv =====
// Shared constants and the item, report and divider request/response types for the vibration window statistics core.
`default_nettype none
package vws_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COUNT_BITS  = 16;
    localparam int CROSS_BITS  = 8;
    localparam int SUM_W       = SAMPLE_W + COUNT_BITS + 1;
    localparam int ELAPSED_W   = 22;
    localparam int TOTAL_W     = 16;
    localparam int CROSS_OUT_W = 8;
    localparam int CNT_EXT_W   = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
    localparam int CR_EXT_W    = (CROSS_BITS > CROSS_OUT_W) ? CROSS_BITS : CROSS_OUT_W;
    localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX    = {ELAPSED_W{1'b1}};
    localparam logic [ELAPSED_W-1:0]  DEFAULT_WINDOW = ELAPSED_W'(10000);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX      = {COUNT_BITS{1'b1}};
    localparam logic [CROSS_BITS-1:0] CROSS_MAX      = {CROSS_BITS{1'b1}};
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX      = {TOTAL_W{1'b1}};
    localparam logic [CROSS_OUT_W-1:0] CROSS_OUT_MAX = {CROSS_OUT_W{1'b1}};

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } item_t;

    typedef struct packed {
        logic [1:0]                 axis;
        logic signed [SAMPLE_W-1:0] max;
        logic signed [SAMPLE_W-1:0] min;
        logic signed [SAMPLE_W-1:0] mean;
        logic [CROSS_OUT_W-1:0]     crossings;
        logic [TOTAL_W-1:0]         total;
        logic                       last;
    } rpt_t;

    typedef struct packed {
        logic                  start;
        logic [SUM_W-1:0]      dividend;
        logic [COUNT_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/vws_cmd_queue.sv =====
// Front end: input item queue that holds samples and ticks until the back end pops them.
`default_nettype none
module vws_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire vws_pkg::item_t push_item,
    output logic               full,
    input  wire logic          pop,
    output vws_pkg::item_t     head,
    output logic               head_valid
);

    vws_pkg::item_t                slot_reg [vws_pkg::Q_DEPTH];
    logic [vws_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [vws_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [vws_pkg::Q_CNT_W-1:0]   count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign full       = (count_reg == vws_pkg::Q_CNT_W'(vws_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

// ===== rtl/core/vws_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module vws_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire vws_pkg::div_req_t req,
    output vws_pkg::div_rsp_t     rsp
);

    localparam int SW = vws_pkg::SUM_W;
    localparam int CB = vws_pkg::COUNT_BITS;

    logic                          busy_reg;
    logic                          done_reg;
    logic [vws_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          neg_reg;
    logic [SW-1:0]                 quo_reg;
    logic [CB-1:0]                 rem_reg;
    logic [CB-1:0]                 div_reg;
    logic [CB:0]                   rem_sh;
    logic [CB:0]                   rem_sub;
    logic                          fits;
    logic [SW-1:0]                 mag;
    logic [SW-1:0]                 q_fixed;

    assign mag     = req.dividend[SW-1] ? (~req.dividend + 1'b1) : req.dividend;
    assign rem_sh  = {rem_reg, quo_reg[SW-1]};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign fits    = (rem_sh >= {1'b0, div_reg});
    assign q_fixed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_fixed[vws_pkg::SAMPLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == vws_pkg::DIV_CNT_W'(SW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.dividend[SW-1];
            quo_reg <= mag;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[CB-1:0] : rem_sh[CB-1:0];
            quo_reg <= {quo_reg[SW-2:0], fits};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/vws_back.sv =====
// Back end: per-axis window statistics, tick timing and the window-close report sequencer.
`default_nettype none
module vws_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [vws_pkg::ELAPSED_W-1:0]    cfg_wdata,
    input  wire vws_pkg::item_t                   head,
    input  wire logic                             head_valid,
    output logic                                  pop,
    output vws_pkg::div_req_t                     div_req,
    input  wire vws_pkg::div_rsp_t                div_rsp,
    output logic                                  rpt_push,
    output vws_pkg::rpt_t                         rpt,
    input  wire logic                             rpt_full
);

    localparam int SW = vws_pkg::SAMPLE_W;

    typedef enum logic [1:0] {ST_RUN, ST_START, ST_DIV, ST_EMIT} state_t;

    state_t                              state_reg, state_next;
    logic [1:0]                          axis_reg, axis_next;
    logic [vws_pkg::ELAPSED_W-1:0]       window_reg, window_next;
    logic [vws_pkg::ELAPSED_W-1:0]       elapsed_reg, elapsed_next;
    logic [vws_pkg::COUNT_BITS-1:0]      count_reg, count_next;
    logic                                have_reg, have_next;
    logic signed [SW-1:0]                mean_reg, mean_next;
    logic signed [SW-1:0]                max_reg [3];
    logic signed [SW-1:0]                max_next [3];
    logic signed [SW-1:0]                min_reg [3];
    logic signed [SW-1:0]                min_next [3];
    logic signed [vws_pkg::SUM_W-1:0]    sum_reg [3];
    logic signed [vws_pkg::SUM_W-1:0]    sum_next [3];
    logic [vws_pkg::CROSS_BITS-1:0]      cross_reg [3];
    logic [vws_pkg::CROSS_BITS-1:0]      cross_next [3];
    logic signed [SW-1:0]                prior_reg [3];
    logic signed [SW-1:0]                prior_next [3];
    logic signed [SW-1:0]                last_reg [3];
    logic signed [SW-1:0]                last_next [3];

    logic signed [SW-1:0]                s [3];
    logic [vws_pkg::ELAPSED_W-1:0]       limit;
    logic [vws_pkg::ELAPSED_W-1:0]       el_inc;
    logic                                count_open;
    logic [vws_pkg::CNT_EXT_W-1:0]       cnt_ext;
    logic [vws_pkg::CR_EXT_W-1:0]        cr_ext;

    assign s[0] = head.x;
    assign s[1] = head.y;
    assign s[2] = head.z;

    assign limit      = (window_reg == '0) ? vws_pkg::DEFAULT_WINDOW : window_reg;
    assign el_inc     = (elapsed_reg == vws_pkg::ELAPSED_MAX) ? elapsed_reg
                                                              : elapsed_reg + 1'b1;
    assign count_open = (count_reg != vws_pkg::COUNT_MAX);

    // Report fields for the axis under close
    assign cnt_ext       = vws_pkg::CNT_EXT_W'(count_reg);
    assign cr_ext        = vws_pkg::CR_EXT_W'(cross_reg[axis_reg]);
    assign rpt.axis      = axis_reg;
    assign rpt.max       = max_reg[axis_reg];
    assign rpt.min       = min_reg[axis_reg];
    assign rpt.mean      = mean_reg;
    assign rpt.crossings = (cr_ext > vws_pkg::CR_EXT_W'(vws_pkg::CROSS_OUT_MAX))
                           ? vws_pkg::CROSS_OUT_MAX : cr_ext[vws_pkg::CROSS_OUT_W-1:0];
    assign rpt.total     = (cnt_ext > vws_pkg::CNT_EXT_W'(vws_pkg::TOTAL_MAX))
                           ? vws_pkg::TOTAL_MAX : cnt_ext[vws_pkg::TOTAL_W-1:0];
    assign rpt.last      = (axis_reg == vws_pkg::AXIS_Z);

    assign div_req.start    = (state_reg == ST_START);
    assign div_req.dividend = sum_reg[axis_reg];
    assign div_req.divisor  = count_reg;

    always_comb
    begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        window_next  = cfg_we ? cfg_wdata : window_reg;
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        have_next    = have_reg;
        mean_next    = mean_reg;
        max_next     = max_reg;
        min_next     = min_reg;
        sum_next     = sum_reg;
        cross_next   = cross_reg;
        prior_next   = prior_reg;
        last_next    = last_reg;
        pop          = 1'b0;
        rpt_push     = 1'b0;

        case (state_reg)
            ST_RUN:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head.cmd == vws_pkg::CMD_SAMPLE)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            if (s[a] > max_reg[a])
                                max_next[a] = s[a];
                            if (s[a] < min_reg[a])
                                min_next[a] = s[a];
                            if (count_open)
                                sum_next[a] = sum_reg[a]
                                    + {{(vws_pkg::SUM_W-SW){s[a][SW-1]}}, s[a]};
                            if (((last_reg[a] < prior_reg[a]) && (s[a] > prior_reg[a])) ||
                                ((last_reg[a] > prior_reg[a]) && (s[a] < prior_reg[a])))
                            begin
                                if (cross_reg[a] != vws_pkg::CROSS_MAX)
                                    cross_next[a] = cross_reg[a] + 1'b1;
                            end
                            last_next[a] = s[a];
                        end
                        if (count_open)
                            count_next = count_reg + 1'b1;
                        have_next = 1'b1;
                    end
                    else
                    begin
                        elapsed_next = el_inc;
                        if (el_inc > limit)
                        begin
                            elapsed_next = '0;
                            if (have_reg)
                            begin
                                axis_next  = vws_pkg::AXIS_X;
                                state_next = ST_START;
                            end
                        end
                    end
                end
            end

            ST_START:
            begin
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    mean_next  = div_rsp.quotient;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!rpt_full)
                begin
                    rpt_push             = 1'b1;
                    prior_next[axis_reg] = mean_reg;
                    if (axis_reg == vws_pkg::AXIS_Z)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            max_next[a]   = vws_pkg::SAMPLE_MIN;
                            min_next[a]   = vws_pkg::SAMPLE_MAX;
                            sum_next[a]   = '0;
                            cross_next[a] = '0;
                        end
                        count_next = '0;
                        have_next  = 1'b0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_START;
                    end
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RUN;
            axis_reg    <= vws_pkg::AXIS_X;
            window_reg  <= vws_pkg::DEFAULT_WINDOW;
            elapsed_reg <= '0;
            count_reg   <= '0;
            have_reg    <= 1'b0;
            mean_reg    <= '0;
            for (int a = 0; a < 3; a++)
            begin
                max_reg[a]   <= vws_pkg::SAMPLE_MIN;
                min_reg[a]   <= vws_pkg::SAMPLE_MAX;
                sum_reg[a]   <= '0;
                cross_reg[a] <= '0;
                prior_reg[a] <= '0;
                last_reg[a]  <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            window_reg  <= window_next;
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
            have_reg    <= have_next;
            mean_reg    <= mean_next;
            max_reg     <= max_next;
            min_reg     <= min_next;
            sum_reg     <= sum_next;
            cross_reg   <= cross_next;
            prior_reg   <= prior_next;
            last_reg    <= last_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/vws_rpt_queue.sv =====
// Result queue holding per-axis reports until the consumer pops them.
`default_nettype none
module vws_rpt_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire vws_pkg::rpt_t push_rpt,
    output logic               full,
    input  wire logic          pop,
    output vws_pkg::rpt_t      head,
    output logic               empty
);

    vws_pkg::rpt_t                 slot_reg [vws_pkg::Q_DEPTH];
    logic [vws_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [vws_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [vws_pkg::Q_CNT_W-1:0]   count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (count_reg == vws_pkg::Q_CNT_W'(vws_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_rpt;
    end

endmodule
`default_nettype wire

// ===== rtl/core/vibration_window_stats_core.sv =====
// Top level of the vibration window statistics core: front queue, back end, divider, result queue.
// Order: a sample or tick is taken up by the back end from the head of the front queue;
//   a closing tick steps it through ST_START, ST_DIV and ST_EMIT, which pushes the first report.
// Throughput: one sample or non-closing tick per cycle while the back end is in ST_RUN.
//   A window close holds the back end while the one-bit-per-cycle divider, shared by the
//   three axes, works each axis in turn; items queue in front meanwhile and full rises.
// Reset: rst_n asynchronous, active low; clears both queues, the statistics to their empty
//   window values, the prior means and last samples to zero, and window_ms to 10000.
`default_nettype none
module vibration_window_stats_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        window_ms_we,
    input  wire logic [21:0] window_ms_wdata,
    // input transactions
    input  wire logic        push,
    output logic             full,
    input  wire logic        cmd,
    input  wire logic signed [15:0] x_sample,
    input  wire logic signed [15:0] y_sample,
    input  wire logic signed [15:0] z_sample,
    // result transactions
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       axis,
    output logic signed [15:0] axis_max,
    output logic signed [15:0] axis_min,
    output logic signed [15:0] axis_mean,
    output logic [7:0]       crossings,
    output logic [15:0]      sample_total,
    output logic             last_of_report
);

    vws_pkg::item_t    in_item;
    vws_pkg::item_t    head_item;
    logic              head_valid;
    logic              back_pop;
    vws_pkg::div_req_t div_req;
    vws_pkg::div_rsp_t div_rsp;
    logic              rpt_push;
    vws_pkg::rpt_t     rpt_in;
    logic              rpt_full;
    vws_pkg::rpt_t     rpt_head;

    // Pack the incoming transaction; the tag in cmd steers it in the back end
    assign in_item.cmd = cmd;
    assign in_item.x   = x_sample;
    assign in_item.y   = y_sample;
    assign in_item.z   = z_sample;

    // Front: absorb items while the back end is busy closing a window
    vws_cmd_queue u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (in_item),
        .full       (full),
        .pop        (back_pop),
        .head       (head_item),
        .head_valid (head_valid)
    );

    // Back: update statistics per sample, time the window on ticks, sequence the reports
    vws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (window_ms_we),
        .cfg_wdata  (window_ms_wdata),
        .head       (head_item),
        .head_valid (head_valid),
        .pop        (back_pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .rpt_push   (rpt_push),
        .rpt        (rpt_in),
        .rpt_full   (rpt_full)
    );

    // Mean of each axis: sum over sample count, one quotient bit per cycle
    vws_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Hold reports so a stalled consumer never blocks the front queue directly
    vws_rpt_queue u_results (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (rpt_push),
        .push_rpt (rpt_in),
        .full     (rpt_full),
        .pop      (pop),
        .head     (rpt_head),
        .empty    (empty)
    );

    assign axis           = rpt_head.axis;
    assign axis_max       = rpt_head.max;
    assign axis_min       = rpt_head.min;
    assign axis_mean      = rpt_head.mean;
    assign crossings      = rpt_head.crossings;
    assign sample_total   = rpt_head.total;
    assign last_of_report = rpt_head.last;

endmodule
`default_nettype wire
